[rtl/nec_enc_pkg.sv]
// Shared types, codes and widths for the NEC infrared frame encoder.
package nec_enc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned OP_W        = 3;
    localparam int unsigned PHASE_CODE_W = 4;
    localparam int unsigned BIT_IDX_W   = 4;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_COUNT   = 6;
    localparam int unsigned FRAME_BYTES = 4;
    localparam int unsigned IN_DATA_W   = 40;
    localparam int unsigned OUT_DATA_W  = 8;
    localparam int unsigned LAST_BIT_IDX = 9;

    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_SEND_STD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND_CUSTOM = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL      = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP        = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP   = 3'd5;

    localparam logic [BYTE_W-1:0] RST_LEADER_MARK  = 8'd15;
    localparam logic [BYTE_W-1:0] RST_LEADER_SPACE = 8'd8;
    localparam logic [BYTE_W-1:0] RST_REPEAT_SPACE = 8'd4;
    localparam logic [BYTE_W-1:0] RST_ONE_SPACE    = 8'd3;
    localparam logic [BYTE_W-1:0] RST_ZERO_SPACE   = 8'd1;
    localparam logic [BYTE_W-1:0] RST_REPEAT_GAP   = 8'd171;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_LEAD   = 9'b000000010,
        PH_RLEAD  = 9'b000000100,
        PH_LSPACE = 9'b000001000,
        PH_BYTE0  = 9'b000010000,
        PH_BYTE1  = 9'b000100000,
        PH_BYTE2  = 9'b001000000,
        PH_BYTE3  = 9'b010000000,
        PH_GAP    = 9'b100000000
    } t_phase;

    typedef enum logic [1:0] {
        RP_NONE  = 2'd0,
        RP_ARMED = 2'd1,
        RP_RUN   = 2'd2
    } t_repeat;

    typedef struct packed {
        logic                    accepted;
        logic [PHASE_CODE_W-1:0] phase_code;
        logic                    busy_res;
        logic                    ir_mark;
    } t_result;

    function automatic logic [PHASE_CODE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_CODE_W-1:0] code;
        case (ph)
            PH_IDLE:   code = 4'd0;
            PH_LEAD:   code = 4'd1;
            PH_RLEAD:  code = 4'd2;
            PH_LSPACE: code = 4'd3;
            PH_BYTE0:  code = 4'd4;
            PH_BYTE1:  code = 4'd5;
            PH_BYTE2:  code = 4'd6;
            PH_BYTE3:  code = 4'd7;
            PH_GAP:    code = 4'd8;
            default:   code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

[rtl/nec_ir_frame_encoder.sv]
// NEC infrared frame encoder: tick-driven frame state machine with stream ports.
//
// Each input word carries one operation (tick, standard send, custom send,
// cancel repeating, stop) and produces exactly one result word with the
// mark/space level, busy flag, phase code and send-accepted flag after that
// operation. One word is taken per clock cycle while the skid register is empty;
// the state update and the result are computed in one pass from the state
// registers and the incoming word, and the result is registered in the output stage.
// A two-entry output stage (output register plus skid register) lets input
// keep flowing while a result waits; input stalls only when both are full.
// Timing registers are written through the config channel, which is always
// ready; write them only while the encoder is idle.
module nec_ir_frame_encoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [7:0] address_byte, [15:8] address_check_byte, [23:16] command_byte,
    // [31:24] command_check_byte, [32] repeat_request, [39:33] zero
    input  logic [nec_enc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [2:0] operation
    input  logic [nec_enc_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [0] ir_mark, [1] busy_res, [5:2] phase_code, [6] accepted, [7] zero
    output logic [nec_enc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nec_enc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nec_enc_pkg::BYTE_W-1:0]       i_cfg_data
);

    logic [nec_enc_pkg::BYTE_W-1:0] r_cfg [nec_enc_pkg::CFG_COUNT];
    logic [nec_enc_pkg::BYTE_W-1:0] r_frame [nec_enc_pkg::FRAME_BYTES];
    logic [nec_enc_pkg::BYTE_W-1:0] n_frame [nec_enc_pkg::FRAME_BYTES];

    nec_enc_pkg::t_phase            r_phase, n_phase;
    nec_enc_pkg::t_repeat           r_repeat, n_repeat;
    logic [nec_enc_pkg::BYTE_W-1:0] r_tick, n_tick;
    logic [nec_enc_pkg::BIT_IDX_W-1:0] r_bit_idx, n_bit_idx;
    logic                           r_in_space, n_in_space;
    logic                           r_level, n_level;

    nec_enc_pkg::t_result           r_out, r_skid, n_res;
    logic                           r_out_valid, r_skid_valid;

    logic [nec_enc_pkg::OP_W-1:0]   op;
    logic [nec_enc_pkg::BYTE_W-1:0] addr_b, addr_chk_b, cmd_b, cmd_chk_b;
    logic                           rep_req;
    logic                           s_accept, m_take, accepted;
    logic [nec_enc_pkg::BYTE_W-1:0] cur_byte, space_lim, bt_tick;
    logic [nec_enc_pkg::BIT_IDX_W-1:0] bt_bit_idx, nxt_idx;
    logic                           cur_bit, nxt_bit, bt_in_space, bt_level;

    assign op         = i_s_axis_tuser;
    assign addr_b     = i_s_axis_tdata[7:0];
    assign addr_chk_b = i_s_axis_tdata[15:8];
    assign cmd_b      = i_s_axis_tdata[23:16];
    assign cmd_chk_b  = i_s_axis_tdata[31:24];
    assign rep_req    = i_s_axis_tdata[32];

    assign o_s_axis_tready = !r_skid_valid;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_take          = r_out_valid && i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};
    assign o_cfg_ready     = 1'b1;

    // bit-period step shared by the four byte phases
    always_comb begin
        case (r_phase)
            nec_enc_pkg::PH_BYTE1: cur_byte = r_frame[1];
            nec_enc_pkg::PH_BYTE2: cur_byte = r_frame[2];
            nec_enc_pkg::PH_BYTE3: cur_byte = r_frame[3];
            default:               cur_byte = r_frame[0];
        endcase
        cur_bit     = !r_bit_idx[3] && cur_byte[r_bit_idx[2:0]];
        nxt_idx     = r_bit_idx + 4'd1;
        nxt_bit     = !nxt_idx[3] && cur_byte[nxt_idx[2:0]];
        space_lim   = cur_bit ? r_cfg[nec_enc_pkg::CFG_ONE_SPACE]
                              : r_cfg[nec_enc_pkg::CFG_ZERO_SPACE];
        bt_tick     = r_tick + 8'd1;
        bt_in_space = r_in_space;
        bt_level    = r_level;
        bt_bit_idx  = r_bit_idx;
        if (!r_in_space) begin
            bt_level    = 1'b0;
            bt_in_space = 1'b1;
            bt_tick     = '0;
        end
        if (bt_tick == space_lim) begin
            bt_level    = 1'b1;
            bt_tick     = '0;
            bt_in_space = 1'b0;
            bt_bit_idx  = nxt_idx;
            // a zero-length zero space also ends the following zero bit at once
            if (cur_bit && !nxt_bit && r_cfg[nec_enc_pkg::CFG_ZERO_SPACE] == '0) begin
                bt_bit_idx = r_bit_idx + 4'd2;
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_repeat   = r_repeat;
        n_tick     = r_tick;
        n_bit_idx  = r_bit_idx;
        n_in_space = r_in_space;
        n_level    = r_level;
        n_frame    = r_frame;
        accepted   = 1'b0;
        case (op)
            nec_enc_pkg::OP_TICK: begin
                case (r_phase)
                    nec_enc_pkg::PH_GAP: begin
                        n_tick  = r_tick + 8'd1;
                        n_level = 1'b0;
                        if (n_tick >= r_cfg[nec_enc_pkg::CFG_REPEAT_GAP]) begin
                            n_level = 1'b1;
                            n_phase = nec_enc_pkg::PH_RLEAD;
                            n_tick  = '0;
                        end
                    end
                    nec_enc_pkg::PH_LEAD, nec_enc_pkg::PH_RLEAD: begin
                        n_tick  = r_tick + 8'd1;
                        n_level = 1'b1;
                        if (n_tick > r_cfg[nec_enc_pkg::CFG_LEADER_MARK]) begin
                            n_level = 1'b0;
                            n_phase = nec_enc_pkg::PH_LSPACE;
                            n_tick  = '0;
                        end
                    end
                    nec_enc_pkg::PH_LSPACE: begin
                        n_tick = r_tick + 8'd1;
                        if (r_repeat == nec_enc_pkg::RP_RUN) begin
                            if (n_tick >= r_cfg[nec_enc_pkg::CFG_REPEAT_SPACE]) begin
                                n_level = 1'b1;
                                n_phase = nec_enc_pkg::PH_GAP;
                                n_tick  = '0;
                            end
                        end else if (n_tick >= r_cfg[nec_enc_pkg::CFG_LEADER_SPACE]) begin
                            n_level = 1'b1;
                            n_phase = nec_enc_pkg::PH_BYTE0;
                            n_tick  = '0;
                        end
                    end
                    nec_enc_pkg::PH_BYTE0, nec_enc_pkg::PH_BYTE1,
                    nec_enc_pkg::PH_BYTE2: begin
                        n_tick     = bt_tick;
                        n_in_space = bt_in_space;
                        n_level    = bt_level;
                        n_bit_idx  = bt_bit_idx;
                        if (bt_bit_idx[3]) begin
                            n_level   = 1'b1;
                            n_bit_idx = '0;
                            n_tick    = '0;
                            case (r_phase)
                                nec_enc_pkg::PH_BYTE0: n_phase = nec_enc_pkg::PH_BYTE1;
                                nec_enc_pkg::PH_BYTE1: n_phase = nec_enc_pkg::PH_BYTE2;
                                default:               n_phase = nec_enc_pkg::PH_BYTE3;
                            endcase
                        end
                    end
                    nec_enc_pkg::PH_BYTE3: begin
                        n_tick     = bt_tick;
                        n_in_space = bt_in_space;
                        n_level    = bt_level;
                        n_bit_idx  = bt_bit_idx;
                        if (bt_bit_idx > 4'(nec_enc_pkg::BYTE_W)) begin
                            n_level   = 1'b0;
                            n_tick    = '0;
                            n_bit_idx = '0;
                            if (r_repeat == nec_enc_pkg::RP_NONE) begin
                                n_phase = nec_enc_pkg::PH_IDLE;
                            end else if (r_repeat == nec_enc_pkg::RP_ARMED) begin
                                n_repeat = nec_enc_pkg::RP_RUN;
                                n_phase  = nec_enc_pkg::PH_GAP;
                            end
                        end
                    end
                    default: begin
                        n_level    = 1'b0;
                        n_repeat   = nec_enc_pkg::RP_NONE;
                        n_phase    = nec_enc_pkg::PH_IDLE;
                        n_tick     = '0;
                        n_in_space = 1'b0;
                        n_bit_idx  = '0;
                    end
                endcase
            end
            nec_enc_pkg::OP_SEND_STD, nec_enc_pkg::OP_SEND_CUSTOM: begin
                if (r_phase == nec_enc_pkg::PH_IDLE || r_phase == nec_enc_pkg::PH_RLEAD) begin
                    n_frame[0] = addr_b;
                    n_frame[1] = (op == nec_enc_pkg::OP_SEND_STD) ? ~addr_b : addr_chk_b;
                    n_frame[2] = cmd_b;
                    n_frame[3] = (op == nec_enc_pkg::OP_SEND_STD) ? ~cmd_b : cmd_chk_b;
                    n_tick     = '0;
                    n_bit_idx  = '0;
                    n_repeat   = rep_req ? nec_enc_pkg::RP_ARMED : nec_enc_pkg::RP_NONE;
                    n_phase    = nec_enc_pkg::PH_LEAD;
                    accepted   = 1'b1;
                end
            end
            nec_enc_pkg::OP_CANCEL: begin
                n_repeat = nec_enc_pkg::RP_NONE;
            end
            nec_enc_pkg::OP_STOP: begin
                n_level    = 1'b0;
                n_repeat   = nec_enc_pkg::RP_NONE;
                n_phase    = nec_enc_pkg::PH_IDLE;
                n_tick     = '0;
                n_in_space = 1'b0;
                n_bit_idx  = '0;
            end
            default: begin
            end
        endcase
        n_res.ir_mark    = n_level;
        n_res.busy_res   = (n_phase != nec_enc_pkg::PH_IDLE);
        n_res.phase_code = nec_enc_pkg::phase_code(n_phase);
        n_res.accepted   = accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= nec_enc_pkg::PH_IDLE;
            r_repeat   <= nec_enc_pkg::RP_NONE;
            r_tick     <= '0;
            r_bit_idx  <= '0;
            r_in_space <= 1'b0;
            r_level    <= 1'b0;
            for (int i = 0; i < nec_enc_pkg::FRAME_BYTES; i++) begin
                r_frame[i] <= '0;
            end
        end else if (s_accept) begin
            r_phase    <= n_phase;
            r_repeat   <= n_repeat;
            r_tick     <= n_tick;
            r_bit_idx  <= n_bit_idx;
            r_in_space <= n_in_space;
            r_level    <= n_level;
            r_frame    <= n_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[nec_enc_pkg::CFG_LEADER_MARK]  <= nec_enc_pkg::RST_LEADER_MARK;
            r_cfg[nec_enc_pkg::CFG_LEADER_SPACE] <= nec_enc_pkg::RST_LEADER_SPACE;
            r_cfg[nec_enc_pkg::CFG_REPEAT_SPACE] <= nec_enc_pkg::RST_REPEAT_SPACE;
            r_cfg[nec_enc_pkg::CFG_ONE_SPACE]    <= nec_enc_pkg::RST_ONE_SPACE;
            r_cfg[nec_enc_pkg::CFG_ZERO_SPACE]   <= nec_enc_pkg::RST_ZERO_SPACE;
            r_cfg[nec_enc_pkg::CFG_REPEAT_GAP]   <= nec_enc_pkg::RST_REPEAT_GAP;
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index < nec_enc_pkg::CFG_IDX_W'(nec_enc_pkg::CFG_COUNT)) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (s_accept) begin
            if (!r_out_valid || m_take) begin
                r_out       <= n_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end else if (m_take) begin
            r_out_valid <= 1'b0;
        end
    end

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register not one-hot");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while output register is empty");

    a_stop_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && op == nec_enc_pkg::OP_STOP |=> r_phase == nec_enc_pkg::PH_IDLE)
        else $error("stop did not return to idle");

    a_bit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_idx <= 4'(nec_enc_pkg::LAST_BIT_IDX))
        else $error("bit index out of range");

    a_accept_leads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && accepted |=> r_phase == nec_enc_pkg::PH_LEAD && r_tick == '0)
        else $error("accepted send did not start a leader");

endmodule
